// File: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Sizes, types and codes shared by the allocator and its
// checker.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int unsigned HEAP_BYTES   = 65536;
   localparam int unsigned PAGE_BYTES   = 4096;
   localparam int unsigned HEADER_BYTES = 4;

   localparam int unsigned ADDR_W     = $clog2(HEAP_BYTES);
   localparam int unsigned SIZE_W     = ADDR_W + 1;
   localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int unsigned HEAP_PAGES = HEAP_BYTES / PAGE_BYTES;
   localparam int unsigned HDR_W      = SIZE_W + 1;

   // Field widths of the ports.
   localparam int unsigned PAGES_W    = 5;
   localparam int unsigned USED_W     = 17;
   localparam int unsigned REQ_W      = 16;
   localparam int unsigned MINC_W     = 13;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;

   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [SIZE_W-1:0]     size_type;
   typedef logic [SIZE_W:0]       sum_type;
   typedef logic [PAGES_W-1:0]    pages_type;
   typedef logic [PAGES_W:0]      npages_type;
   typedef logic [USED_W-1:0]     used_type;
   typedef logic [USED_W:0]       usum_type;
   typedef logic [MINC_W-1:0]     minc_type;
   typedef logic [REQ_W-1:0]      req_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [1:0]            status_type;

   // In-band chunk header as it sits in the header RAM.
   typedef struct packed {
      logic     used;
      size_type size;
   } hdr_type;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_NULL    = 2'd1;
   localparam status_type STATUS_NO_HEAP = 2'd2;
   localparam status_type STATUS_CORRUPT = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam csr_idx_type CSR_HEAP_LIMIT = 2'd0;
   localparam csr_idx_type CSR_MIN_CHUNK  = 2'd1;

   localparam pages_type LIMIT_RESET = pages_type'(HEAP_PAGES);
   localparam minc_type  MINC_RESET  = minc_type'(16);
   localparam used_type  USED_MAX    = '1;

   localparam hdr_type INIT_HDR = '{used: 1'b0, size: size_type'(PAGE_BYTES)};

endpackage
`default_nettype wire

// File: hw/rtl/ffha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int unsigned WIDTH = 18,
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Allocates and frees chunks of a byte heap whose chunk headers live in a
// header RAM, walking chunks first-fit and merging freed chunks forward.
//
//   channel   direction  handshake              carries
//   req_      in         req_valid/req_ready    func, size, address to free
//   rsp_      out        rsp_valid/rsp_ready    data address, status, totals
//   csr_      in         csr_valid/csr_ready    register index, write data
//
// After reset the header RAM is cleared one entry per cycle, every entry of
// it, before the first request is taken; csr writes are taken throughout.
// An allocate visits chunk headers in turn, growing the heap and splitting
// the claimed chunk where needed; a free reads the headers after the freed
// chunk to merge them. A null or rejected request goes straight to its
// response. A stalled response holds the block only when its next response
// is ready.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_func,
   input  wire ffha_pkg::req_type      req_size,
   input  wire ffha_pkg::addr_type     req_free_addr,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ffha_pkg::addr_type          rsp_data_addr,
   output ffha_pkg::status_type        rsp_status,
   output ffha_pkg::used_type          rsp_bytes_used,
   output ffha_pkg::pages_type         rsp_heap_pages,
   // register write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire ffha_pkg::csr_idx_type  csr_index,
   input  wire ffha_pkg::csr_data_type csr_wdata
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_SPLIT  = 3'd4;
   localparam logic [2:0] S_FCHK   = 3'd5;
   localparam logic [2:0] S_FMERGE = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   // control state
   logic [2:0]           state_ff, state_in;
   ffha_pkg::addr_type   clr_cnt_ff, clr_cnt_in;
   logic                 fwd_ff, fwd_in;
   ffha_pkg::pages_type  pages_ff, pages_in;
   ffha_pkg::used_type   used_ff, used_in;
   ffha_pkg::pages_type  limit_ff, limit_in;
   ffha_pkg::minc_type   minc_cfg_ff, minc_cfg_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload state
   logic                 func_ff, func_in;
   ffha_pkg::req_type    size_ff, size_in;
   ffha_pkg::addr_type   faddr_ff, faddr_in;
   ffha_pkg::size_type   real_ff, real_in;
   ffha_pkg::addr_type   chunk_ff, chunk_in;
   ffha_pkg::addr_type   other_ff, other_in;
   ffha_pkg::size_type   merged_ff, merged_in;
   ffha_pkg::size_type   rem_ff, rem_in;
   ffha_pkg::size_type   fwd_size_ff, fwd_size_in;
   ffha_pkg::addr_type   res_addr_ff, res_addr_in;
   ffha_pkg::status_type res_status_ff, res_status_in;
   ffha_pkg::addr_type   rsp_addr_ff, rsp_addr_in;
   ffha_pkg::status_type rsp_status_ff, rsp_status_in;
   ffha_pkg::used_type   rsp_used_ff, rsp_used_in;
   ffha_pkg::pages_type  rsp_pages_ff, rsp_pages_in;

   // header RAM port signals
   logic                         wr_en;
   ffha_pkg::addr_type           wr_addr;
   ffha_pkg::hdr_type            wr_hdr;
   logic                         rd_en;
   ffha_pkg::addr_type           rd_addr;
   logic [ffha_pkg::HDR_W-1:0]   rd_data;
   ffha_pkg::hdr_type            hdr;

   // datapath helpers
   ffha_pkg::size_type   minc;
   ffha_pkg::size_type   end_bytes;
   ffha_pkg::pages_type  lim_pages;
   ffha_pkg::size_type   req_real;
   ffha_pkg::sum_type    walk_next;
   ffha_pkg::npages_type grow_n;
   ffha_pkg::npages_type grow_sum;
   ffha_pkg::size_type   fit_rem;
   ffha_pkg::sum_type    fit_other;
   logic                 fit_split;
   ffha_pkg::usum_type   used_add;
   ffha_pkg::used_type   used_sub;
   ffha_pkg::addr_type   free_chunk;
   ffha_pkg::sum_type    merge_next;
   ffha_pkg::size_type   merge_size;
   logic                 req_fire;
   logic                 out_free;

   ffha_ram #(
      .WIDTH (ffha_pkg::HDR_W),
      .DEPTH (ffha_pkg::HEAP_BYTES)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_hdr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A freshly grown chunk is not in the RAM yet; its header comes from fwd_size_ff.
   assign hdr = fwd_ff ? ffha_pkg::hdr_type'{used: 1'b0, size: fwd_size_ff}
                       : ffha_pkg::hdr_type'(rd_data);

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign csr_ready = 1'b1;

   assign minc      = (minc_cfg_ff == '0) ? ffha_pkg::size_type'(1)
                                          : ffha_pkg::size_type'(minc_cfg_ff);
   assign end_bytes = ffha_pkg::size_type'({pages_ff, {ffha_pkg::PAGE_SHIFT{1'b0}}});
   assign lim_pages = (limit_ff > ffha_pkg::LIMIT_RESET) ? ffha_pkg::LIMIT_RESET : limit_ff;
   assign req_real  = ffha_pkg::size_type'(size_ff) +
                      ffha_pkg::size_type'(ffha_pkg::HEADER_BYTES);

   assign walk_next = ffha_pkg::sum_type'(chunk_ff) + ffha_pkg::sum_type'(hdr.size);
   assign grow_n    = ffha_pkg::npages_type'(real_ff >> ffha_pkg::PAGE_SHIFT) +
                      ffha_pkg::npages_type'(1);
   assign grow_sum  = ffha_pkg::npages_type'(pages_ff) + grow_n;

   assign fit_rem   = hdr.size - real_ff;
   assign fit_other = ffha_pkg::sum_type'(chunk_ff) + ffha_pkg::sum_type'(real_ff);
   assign fit_split = (fit_rem >= minc) && (fit_other < ffha_pkg::sum_type'(end_bytes));

   assign used_add  = ffha_pkg::usum_type'(used_ff) + ffha_pkg::usum_type'(real_ff);
   assign used_sub  = (used_ff > ffha_pkg::used_type'(hdr.size))
                      ? used_ff - ffha_pkg::used_type'(hdr.size) : '0;

   assign free_chunk = faddr_ff - ffha_pkg::addr_type'(ffha_pkg::HEADER_BYTES);
   assign merge_next = ffha_pkg::sum_type'(other_ff) + ffha_pkg::sum_type'(hdr.size);
   assign merge_size = merged_ff + hdr.size;

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      fwd_in        = 1'b0;
      pages_in      = pages_ff;
      used_in       = used_ff;
      limit_in      = limit_ff;
      minc_cfg_in   = minc_cfg_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;

      func_in       = func_ff;
      size_in       = size_ff;
      faddr_in      = faddr_ff;
      real_in       = real_ff;
      chunk_in      = chunk_ff;
      other_in      = other_ff;
      merged_in     = merged_ff;
      rem_in        = rem_ff;
      fwd_size_in   = fwd_size_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_pages_in  = rsp_pages_ff;

      wr_en   = 1'b0;
      wr_addr = chunk_ff;
      wr_hdr  = '{used: 1'b0, size: merged_ff};
      rd_en   = 1'b0;
      rd_addr = '0;

      if (csr_valid && csr_ready) begin
         if (csr_index == ffha_pkg::CSR_HEAP_LIMIT) begin
            limit_in = ffha_pkg::pages_type'(csr_wdata);
         end else if (csr_index == ffha_pkg::CSR_MIN_CHUNK) begin
            minc_cfg_in = ffha_pkg::minc_type'(csr_wdata);
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_hdr     = (clr_cnt_ff == '0) ? ffha_pkg::INIT_HDR : '0;
            clr_cnt_in = clr_cnt_ff + ffha_pkg::addr_type'(1);
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               func_in  = req_func;
               size_in  = req_size;
               faddr_in = req_free_addr;
               state_in = S_START;
            end
         end

         S_START: begin
            res_addr_in = '0;
            if (func_ff == ffha_pkg::FUNC_ALLOC) begin
               if (size_ff == '0) begin
                  res_status_in = ffha_pkg::STATUS_NULL;
                  state_in      = S_DONE;
               end else begin
                  real_in  = (req_real < minc) ? minc : req_real;
                  chunk_in = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_WALK;
               end
            end else begin
               if (faddr_ff == '0) begin
                  res_status_in = ffha_pkg::STATUS_NULL;
                  state_in      = S_DONE;
               end else if ((faddr_ff < ffha_pkg::addr_type'(ffha_pkg::HEADER_BYTES)) ||
                            (ffha_pkg::size_type'(free_chunk) >= end_bytes)) begin
                  res_status_in = ffha_pkg::STATUS_CORRUPT;
                  state_in      = S_DONE;
               end else begin
                  chunk_in = free_chunk;
                  rd_en    = 1'b1;
                  rd_addr  = free_chunk;
                  state_in = S_FCHK;
               end
            end
         end

         S_WALK: begin
            priority if (!hdr.used && (hdr.size >= real_ff)) begin
               // First fit found: claim it, splitting off the tail when it is large enough.
               res_addr_in   = chunk_ff + ffha_pkg::addr_type'(ffha_pkg::HEADER_BYTES);
               res_status_in = ffha_pkg::STATUS_OK;
               used_in       = (used_add > ffha_pkg::usum_type'(ffha_pkg::USED_MAX))
                               ? ffha_pkg::USED_MAX : ffha_pkg::used_type'(used_add);
               wr_en         = 1'b1;
               wr_addr       = chunk_ff;
               if (fit_split) begin
                  wr_hdr   = '{used: 1'b1, size: real_ff};
                  rem_in   = fit_rem;
                  other_in = ffha_pkg::addr_type'(fit_other);
                  state_in = S_SPLIT;
               end else begin
                  wr_hdr   = '{used: 1'b1, size: hdr.size};
                  state_in = S_DONE;
               end
            end else if (hdr.size == '0) begin
               res_addr_in   = '0;
               res_status_in = ffha_pkg::STATUS_CORRUPT;
               state_in      = S_DONE;
            end else if (walk_next == ffha_pkg::sum_type'(end_bytes)) begin
               // Walk reached the heap end: grow by whole pages within the limit, then the new chunk fits.
               if (grow_sum > ffha_pkg::npages_type'(lim_pages)) begin
                  res_addr_in   = '0;
                  res_status_in = ffha_pkg::STATUS_NO_HEAP;
                  state_in      = S_DONE;
               end else begin
                  chunk_in    = ffha_pkg::addr_type'(walk_next);
                  fwd_in      = 1'b1;
                  fwd_size_in = ffha_pkg::size_type'({grow_n, {ffha_pkg::PAGE_SHIFT{1'b0}}});
                  pages_in    = ffha_pkg::pages_type'(grow_sum);
               end
            end else if (walk_next > ffha_pkg::sum_type'(end_bytes)) begin
               res_addr_in   = '0;
               res_status_in = ffha_pkg::STATUS_CORRUPT;
               state_in      = S_DONE;
            end else begin
               chunk_in = ffha_pkg::addr_type'(walk_next);
               rd_en    = 1'b1;
               rd_addr  = ffha_pkg::addr_type'(walk_next);
            end
         end

         S_SPLIT: begin
            wr_en    = 1'b1;
            wr_addr  = other_ff;
            wr_hdr   = '{used: 1'b0, size: rem_ff};
            state_in = S_DONE;
         end

         S_FCHK: begin
            if ((hdr.size == '0) || !hdr.used) begin
               res_status_in = ffha_pkg::STATUS_CORRUPT;
               state_in      = S_DONE;
            end else begin
               res_status_in = ffha_pkg::STATUS_OK;
               used_in       = used_sub;
               merged_in     = hdr.size;
               if (walk_next >= ffha_pkg::sum_type'(end_bytes)) begin
                  wr_en    = 1'b1;
                  wr_addr  = chunk_ff;
                  wr_hdr   = '{used: 1'b0, size: hdr.size};
                  state_in = S_DONE;
               end else begin
                  other_in = ffha_pkg::addr_type'(walk_next);
                  rd_en    = 1'b1;
                  rd_addr  = ffha_pkg::addr_type'(walk_next);
                  state_in = S_FMERGE;
               end
            end
         end

         S_FMERGE: begin
            // The freed chunk's header is written once, when the merge stops.
            if (hdr.used || (hdr.size == '0) ||
                (merge_next > ffha_pkg::sum_type'(end_bytes))) begin
               wr_en    = 1'b1;
               wr_addr  = chunk_ff;
               wr_hdr   = '{used: 1'b0, size: merged_ff};
               state_in = S_DONE;
            end else if (merge_next >= ffha_pkg::sum_type'(end_bytes)) begin
               wr_en    = 1'b1;
               wr_addr  = chunk_ff;
               wr_hdr   = '{used: 1'b0, size: merge_size};
               state_in = S_DONE;
            end else begin
               merged_in = merge_size;
               other_in  = ffha_pkg::addr_type'(merge_next);
               rd_en     = 1'b1;
               rd_addr   = ffha_pkg::addr_type'(merge_next);
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_used_in   = used_ff;
               rsp_pages_in  = pages_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         fwd_ff       <= 1'b0;
         pages_ff     <= ffha_pkg::pages_type'(1);
         used_ff      <= '0;
         limit_ff     <= ffha_pkg::LIMIT_RESET;
         minc_cfg_ff  <= ffha_pkg::MINC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         fwd_ff       <= fwd_in;
         pages_ff     <= pages_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         minc_cfg_ff  <= minc_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      size_ff       <= size_in;
      faddr_ff      <= faddr_in;
      real_ff       <= real_in;
      chunk_ff      <= chunk_in;
      other_ff      <= other_in;
      merged_ff     <= merged_in;
      rem_ff        <= rem_in;
      fwd_size_ff   <= fwd_size_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_pages_ff  <= rsp_pages_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_addr  = rsp_addr_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bytes_used = rsp_used_ff;
   assign rsp_heap_pages = rsp_pages_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ffha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Port-level properties of the allocator, bound to its top level.
// ----------------------------------------------------------------------------
module ffha_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire ffha_pkg::addr_type   rsp_data_addr,
   input wire ffha_pkg::status_type rsp_status,
   input wire ffha_pkg::used_type   rsp_bytes_used,
   input wire ffha_pkg::pages_type  rsp_heap_pages
);

   // A stalled response keeps its whole payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_addr) &&
      $stable(rsp_status) && $stable(rsp_bytes_used) && $stable(rsp_heap_pages))
      else $error("response changed while stalled");

   // Only a successful transaction may return a data address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ffha_pkg::STATUS_OK) |-> rsp_data_addr == '0)
      else $error("data address on a failed transaction");

   // The heap always holds between one page and the whole heap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heap_pages != '0) &&
      (rsp_heap_pages <= ffha_pkg::pages_type'(ffha_pkg::HEAP_PAGES)))
      else $error("heap page count out of range");

   // One transaction at a time: the request side closes right after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in progress");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_data_addr  (rsp_data_addr),
   .rsp_status     (rsp_status),
   .rsp_bytes_used (rsp_bytes_used),
   .rsp_heap_pages (rsp_heap_pages)
);
`default_nettype wire
